// File: hw/rtl/lrupr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared word types, cell control struct and default sizes.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;
    localparam int CFG_W         = 4;
    localparam int FIELD_W       = 16;

    typedef struct packed {
        logic [FIELD_W-1:0] page_number;
        logic               restart;
    } t_in_word;

    typedef struct packed {
        logic               fault;
        logic               evicted_valid;
        logic [FIELD_W-1:0] evicted_page;
        logic [FIELD_W-1:0] fault_count;
    } t_out_word;

    // Per-cell control for one reference
    typedef struct packed {
        logic step;   // a reference is being taken this cycle
        logic flush;  // restart: treat the stored entry as empty
        logic shift;  // take the neighbor's entry
    } t_cell_ctl;

endpackage

// File: hw/rtl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement unit
// Tracks resident pages in a shifting LRU stack and reports faults/evictions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): one page reference
//   per word, with a restart flag that empties all frames and zeroes the
//   fault count before the reference is handled.
//   Output channel (o_out_valid / i_out_stall / o_out_word): one result word
//   per reference: fault, eviction flag, evicted page, running fault count.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
//   number of active frames; always ready. Write only while idle.
// Latency and throughput:
//   A reference is resolved in the cycle it is taken: all stack cells compare
//   against it in parallel and shift in one step. The result appears in the
//   output register in the next cycle. One word per cycle unless stalled.
// Stall:
//   The output register holds a pending result; the input stalls only while
//   that register is full and the receiver stalls.
// Reset:
//   Empties the stack, clears the fault count, sets active frames to
//   min(8, FRAMES). No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  lrupr_pkg::t_in_word             i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output lrupr_pkg::t_out_word            o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]     i_cfg_data
);
    import lrupr_pkg::*;

    // Stored page width: low PAGE_BITS bits (at most 16) of the 16-bit field
    localparam int PAGE_W  = (PAGE_BITS < FIELD_W) ? PAGE_BITS : FIELD_W;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFG_RST = (FRAMES < 8) ? FRAMES : 8;

    logic [CFG_W-1:0]   r_active;
    logic [CNT_W-1:0]   r_occ;
    logic [CNT_W-1:0]   n_occ;
    logic [FIELD_W-1:0] r_cnt;
    logic [FIELD_W-1:0] n_cnt;
    logic               r_out_valid;
    logic               n_out_valid;
    t_out_word          r_out;
    t_out_word          n_out;

    logic               w_accept;
    logic               w_restart;
    logic [PAGE_W-1:0]  w_key;
    logic [CMP_W-1:0]   w_limit;
    logic [CNT_W-1:0]   w_occ;
    logic [FIELD_W-1:0] w_cnt;
    logic               w_hit;
    logic               w_fill;
    logic [CNT_W-1:0]   w_hit_idx;
    logic [CNT_W-1:0]   w_stop;
    logic [PAGE_W-1:0]  w_victim;

    logic [PAGE_W-1:0]  w_page  [FRAMES];
    logic [FRAMES-1:0]  w_valid;
    logic [FRAMES-1:0]  w_match;
    logic [FRAMES-1:0]  w_tail;
    t_cell_ctl          w_ctl   [FRAMES];

    // Handshakes: drop the stall as soon as the output register can move
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign w_restart = i_in_word.restart;
    assign w_key     = i_in_word.page_number[PAGE_W-1:0];
    assign w_occ     = w_restart ? '0 : r_occ;
    assign w_cnt     = w_restart ? '0 : r_cnt;

    // Clamp active frames into 1..FRAMES
    always_comb begin
        if (r_active == '0) begin
            w_limit = CMP_W'(1);
        end else if (CMP_W'(r_active) > CMP_W'(FRAMES)) begin
            w_limit = CMP_W'(FRAMES);
        end else begin
            w_limit = CMP_W'(r_active);
        end
    end

    // Row of stack cells: position 0 is most recently used
    for (genvar k = 0; k < FRAMES; k++) begin : g_cell
        logic [PAGE_W-1:0] w_prev_page;
        logic              w_prev_valid;

        if (k == 0) begin : g_head
            assign w_prev_page  = w_key;
            assign w_prev_valid = 1'b1;
        end else begin : g_body
            assign w_prev_page  = w_page[k-1];
            assign w_prev_valid = w_valid[k-1];
        end

        if (k == FRAMES - 1) begin : g_last
            assign w_tail[k] = w_valid[k];
        end else begin : g_mid
            assign w_tail[k] = w_valid[k] & ~w_valid[k+1];
        end

        assign w_ctl[k].step  = w_accept;
        assign w_ctl[k].flush = w_restart;
        assign w_ctl[k].shift = (CNT_W'(k) <= w_stop);

        lrupr_cell #(
            .PAGE_W (PAGE_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl[k]),
            .i_key        (w_key),
            .i_prev_page  (w_prev_page),
            .i_prev_valid (w_prev_valid),
            .o_page       (w_page[k]),
            .o_valid      (w_valid[k]),
            .o_match      (w_match[k])
        );
    end

    // Hit position and victim (tail = last valid cell, the LRU page)
    always_comb begin
        w_hit_idx = '0;
        w_victim  = '0;
        for (int k = 0; k < FRAMES; k++) begin
            if (w_match[k]) begin
                w_hit_idx = w_hit_idx | CNT_W'(k);
            end
            if (w_tail[k]) begin
                w_victim = w_victim | w_page[k];
            end
        end
    end

    assign w_hit  = |w_match;
    assign w_fill = CMP_W'(w_occ) < w_limit;

    // Last cell that takes its neighbor's entry on this reference
    always_comb begin
        if (w_hit) begin
            w_stop = w_hit_idx;
        end else if (w_fill) begin
            w_stop = w_occ;
        end else begin
            w_stop = w_occ - CNT_W'(1);
        end
    end

    always_comb begin
        n_occ = r_occ;
        n_cnt = r_cnt;
        if (w_accept) begin
            n_occ = (!w_hit && w_fill) ? (w_occ + CNT_W'(1)) : w_occ;
            if (w_hit || (w_cnt == '1)) begin
                n_cnt = w_cnt;
            end else begin
                n_cnt = w_cnt + FIELD_W'(1);
            end
        end
    end

    always_comb begin
        n_out_valid = w_accept | (r_out_valid & i_out_stall);
        n_out       = r_out;
        if (w_accept) begin
            n_out.fault         = ~w_hit;
            n_out.evicted_valid = ~w_hit & ~w_fill;
            n_out.evicted_page  = (~w_hit & ~w_fill) ? FIELD_W'(w_victim) : '0;
            n_out.fault_count   = n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= CFG_W'(CFG_RST);
            r_occ       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_active <= i_cfg_data;
            end
            r_occ       <= n_occ;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// File: hw/rtl/lrupr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU stack cell
// Holds one stack position: a page and its valid mark; shifts from neighbor.
// ----------------------------------------------------------------------------
module lrupr_cell #(
    parameter int PAGE_W = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrupr_pkg::t_cell_ctl  i_ctl,
    input  logic [PAGE_W-1:0]     i_key,
    input  logic [PAGE_W-1:0]     i_prev_page,
    input  logic                  i_prev_valid,
    output logic [PAGE_W-1:0]     o_page,
    output logic                  o_valid,
    output logic                  o_match
);
    import lrupr_pkg::*;

    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] n_page;
    logic              r_valid;
    logic              n_valid;

    // Valid as seen by this reference (restart empties the stack first)
    assign o_valid = r_valid & ~i_ctl.flush;
    assign o_page  = r_page;
    assign o_match = o_valid && (r_page == i_key);

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        if (i_ctl.step) begin
            if (i_ctl.shift) begin
                n_page  = i_prev_page;
                n_valid = i_prev_valid;
            end else begin
                n_valid = o_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page-reference words into the unit and checks every result word
// against an in-bench LRU predictor: hits, free-frame fills, evictions of the
// least recently used page, restarts, frame-limit settings and single-frame
// thrashing, under several sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    import lrupr_pkg::*;

    localparam int NUM_FRAMES   = FRAMES_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int POOL_DEPTH   = 16;
    localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    t_in_word           in_word   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    t_out_word          out_word;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data  = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    lru_page_replacement i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor state: resident pages, valid marks, recency ranks
    // (0 = most recently used), occupancy, fault total, frame limit.
    // ------------------------------------------------------------------------
    logic [FIELD_W-1:0] res_page  [NUM_FRAMES];
    logic               res_valid [NUM_FRAMES];
    logic [2:0]         res_rank  [NUM_FRAMES];
    int unsigned        res_occupied;
    logic [FIELD_W-1:0] res_faults;
    logic [CFG_W-1:0]   frame_limit_reg;

    t_out_word          pending_results [$];

    // Idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Run statistics
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned ref_count      = 0;
    int unsigned hit_seen       = 0;
    int unsigned fault_seen     = 0;
    int unsigned evict_seen     = 0;
    int unsigned limit_writes   = 0;
    bit          count_saturated = 1'b0;

    // Working set for the random traffic
    logic [FIELD_W-1:0] page_pool [POOL_DEPTH];
    int unsigned        pool_span = 4;

    function automatic void clear_residents();
        for (int i = 0; i < NUM_FRAMES; i++) begin
            res_page[i]  = '0;
            res_valid[i] = 1'b0;
            res_rank[i]  = '0;
        end
        res_occupied = 0;
        res_faults   = '0;
    endfunction

    // Make frame f the most recent; valid frames younger than old_rank age by one.
    function automatic void promote_frame(int f, int old_rank);
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (i != f && res_valid[i] && int'(res_rank[i]) < old_rank)
                res_rank[i] = res_rank[i] + 3'd1;
        end
        res_rank[f] = '0;
    endfunction

    // Resolve one reference against the predicted residents and update them.
    function automatic t_out_word lru_resolve(t_in_word w);
        t_out_word   r;
        int          limit;
        int          f;
        int          oldest;
        bit          hit;
        bit          found;
        r      = '0;
        hit    = 1'b0;
        found  = 1'b0;
        f      = 0;
        oldest = 0;
        if (w.restart)
            clear_residents();
        // Clamp the limit: zero acts as one, above the frame count as the count
        limit = int'(frame_limit_reg);
        if (limit < 1)
            limit = 1;
        if (limit > NUM_FRAMES)
            limit = NUM_FRAMES;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (!hit && res_valid[i] && res_page[i] == w.page_number) begin
                hit = 1'b1;
                f   = i;
            end
        end
        if (hit) begin
            promote_frame(f, int'(res_rank[f]));
        end else begin
            if (res_occupied < limit) begin
                // Fill the lowest-numbered free frame
                for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
                    if (!res_valid[i])
                        f = i;
                end
                res_valid[f] = 1'b1;
                res_page[f]  = w.page_number;
                res_occupied++;
                promote_frame(f, NUM_FRAMES);
            end else begin
                // Evict the oldest valid frame, first one wins a tie
                for (int i = 0; i < NUM_FRAMES; i++) begin
                    if (res_valid[i] && (!found || int'(res_rank[i]) > oldest)) begin
                        oldest = int'(res_rank[i]);
                        f      = i;
                        found  = 1'b1;
                    end
                end
                r.evicted_valid = 1'b1;
                r.evicted_page  = res_page[f];
                res_page[f]     = w.page_number;
                promote_frame(f, oldest);
            end
            if (res_faults != COUNT_MAX)
                res_faults = res_faults + 1'b1;
        end
        r.fault       = !hit;
        r.fault_count = res_faults;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: stall at the rate of the current phase
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it hangs
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_field(string name, int unsigned exp_val, int unsigned act_val);
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, name, exp_val, act_val);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Monitor and checker. All samples are taken at the rising edge, before
    // any driver updates land, so the order of processes does not matter.
    // Check the result word first: it always belongs to an older reference
    // than a word accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_word exp_word;
        if (!rst_n) begin
            clear_residents();
            frame_limit_reg = CFG_W'(NUM_FRAMES);
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: result word with none expected, actual 0x%0h",
                             $time, out_word);
                    mismatch_count++;
                end else begin
                    exp_word = pending_results.pop_front();
                    if (out_word.fault !== exp_word.fault)
                        report_field("fault", exp_word.fault, out_word.fault);
                    if (out_word.evicted_valid !== exp_word.evicted_valid)
                        report_field("evicted_valid", exp_word.evicted_valid,
                                     out_word.evicted_valid);
                    if (out_word.evicted_page !== exp_word.evicted_page)
                        report_field("evicted_page", exp_word.evicted_page,
                                     out_word.evicted_page);
                    if (out_word.fault_count !== exp_word.fault_count)
                        report_field("fault_count", exp_word.fault_count,
                                     out_word.fault_count);
                end
            end
            if (cfg_valid && cfg_ready) begin
                frame_limit_reg = cfg_data;
                limit_writes++;
            end
            if (in_valid && !in_stall) begin
                exp_word = lru_resolve(in_word);
                pending_results = {pending_results, exp_word};
                ref_count++;
                if (exp_word.fault)
                    fault_seen++;
                else
                    hit_seen++;
                if (exp_word.evicted_valid)
                    evict_seen++;
                if (exp_word.fault && exp_word.fault_count == COUNT_MAX)
                    count_saturated = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Send one reference word; return at the edge that accepts it.
    task automatic send_reference(logic [FIELD_W-1:0] page, logic restart);
        t_in_word w;
        w.page_number = page;
        w.restart     = restart;
        // Idle the sender at the rate of the current phase
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        // Hold the word until it is taken
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle.
    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the frame limit while the unit is idle.
    task automatic write_frame_limit(logic [CFG_W-1:0] value);
        settle_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset default of eight frames: fill, hit, evict, extreme page values, restart.
    task automatic test_fill_and_evict();
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h0000, 1'b0);           // hit, page zero goes to the front
        for (int p = 1; p <= 6; p++)
            send_reference(FIELD_W'(p), 1'b0);    // fill the remaining frames
        send_reference(16'h8000, 1'b0);           // evict the oldest page, 0xFFFF
        send_reference(16'h0003, 1'b0);           // hit in the middle of the stack
        send_reference(16'hFFFF, 1'b1);           // restart, then a fresh fault
        settle_idle();
    endtask

    // Frame limits at and beyond the extremes, and lowered below occupancy.
    task automatic test_frame_limits();
        write_frame_limit(4'd0);                  // zero acts as one frame
        send_reference(16'h0005, 1'b1);
        send_reference(16'h0006, 1'b0);
        send_reference(16'h0005, 1'b0);
        write_frame_limit(4'd15);                 // above the frame count
        for (int p = 16; p < 20; p++)
            send_reference(FIELD_W'(p), 1'b0);
        write_frame_limit(4'd2);                  // below occupancy: evict, never shrink
        send_reference(16'h0020, 1'b0);
        send_reference(16'h0021, 1'b0);
        write_frame_limit(4'd8);                  // free frames are usable again
        send_reference(16'h0022, 1'b0);
        settle_idle();
    endtask

    // Thrash one frame with random pages, each unlike the last: every reference after the first evicts.
    task automatic test_single_frame_thrash();
        logic [FIELD_W-1:0] page;
        logic [FIELD_W-1:0] prev_page;
        prev_page = '0;
        write_frame_limit(4'd1);
        send_reference(prev_page, 1'b1);
        for (int n = 0; n < 20; n++) begin
            page = FIELD_W'($urandom);
            if (page == prev_page)
                page = ~prev_page;
            send_reference(page, 1'b0);
            prev_page = page;
        end
        settle_idle();
    endtask

    // Pick a new working set sized from the clamped frame limit up to three pages above it.
    function automatic void refill_pool(logic [CFG_W-1:0] limit);
        int unsigned eff;
        eff = (limit == 0) ? 1 : ((limit > NUM_FRAMES) ? NUM_FRAMES : limit);
        for (int i = 0; i < POOL_DEPTH; i++)
            page_pool[i] = FIELD_W'($urandom);
        pool_span = eff + $urandom_range(0, 3);
    endfunction

    // Mostly references from the working set so hits and evictions keep
    // coming; the rest are stray pages. Restart now and then.
    task automatic send_random_reference();
        logic [FIELD_W-1:0] page;
        logic               restart;
        if ($urandom_range(0, 99) < 5)
            page_pool[$urandom_range(0, POOL_DEPTH - 1)] = FIELD_W'($urandom);
        if ($urandom_range(0, 99) < 90)
            page = page_pool[$urandom_range(0, pool_span - 1)];
        else
            page = FIELD_W'($urandom);
        restart = ($urandom_range(0, 99) < 3);
        send_reference(page, restart);
    endtask

    // Random traffic across idling phases and frame-limit settings.
    task automatic test_random_traffic();
        int unsigned        idle_plan [4] = '{0, 57, 0, 22};
        int unsigned        stall_plan[4] = '{0, 0, 57, 22};
        logic [CFG_W-1:0]   limit;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int seg = 0; seg < 4; seg++) begin
                case (seg)
                    0: begin
                        limit = 4'd1;
                    end
                    1: begin
                        limit = CFG_W'(NUM_FRAMES);
                    end
                    default: begin
                        limit = CFG_W'($urandom_range(0, 15));
                    end
                endcase
                // Keep residents across the write so lowered limits get exercised
                write_frame_limit(limit);
                refill_pool(limit);
                for (int n = 0; n < 82; n++)
                    send_random_reference();
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settle_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_evict();
        test_frame_limits();
        test_single_frame_thrash();
        test_random_traffic();

        settle_idle();
        $display("Covered %0d references: %0d hits, %0d faults, %0d evictions",
                 ref_count, hit_seen, fault_seen, evict_seen);
        $display("Frame limit written %0d times; fault count saturated: %0d",
                 limit_writes, count_saturated);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
